### sv/rrw_pkg.sv
// Package: beat types, queue entry type and result codes for the reorder receive window.
`default_nettype none
package rrw_pkg;

  // Sequence counter holds 0..8.
  localparam int EXP_W = 4;

  // Dispatch queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // Result kind codes.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [2:0]  frame_seq;
    logic [31:0] frame_payload;
  } in_beat_t;

  typedef struct packed {
    logic             out_kind;
    logic [31:0]      out_payload;
    logic [EXP_W-1:0] ack_number;
    logic             last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic        in_win;
    logic [2:0]  frame_seq;
    logic [31:0] frame_payload;
  } q_entry_t;

endpackage
`default_nettype wire

### sv/rrw_front.sv
// Front stage: accepts frames, tags in-window ones and hands them to the queue.
`default_nettype none
module rrw_front #(
  parameter int WINDOW_SIZE = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrw_pkg::in_beat_t in_data,
  output logic                   push_valid,
  input  wire logic              push_full,
  output rrw_pkg::q_entry_t      push_entry
);

  localparam int SLOTS = (WINDOW_SIZE < 8) ? WINDOW_SIZE : 8;
  localparam logic [3:0] SLOTS4 = 4'(SLOTS);

  logic              front_valid_r, front_valid_nxt;
  rrw_pkg::q_entry_t front_entry_r;
  logic              accept;

  assign in_stall   = front_valid_r && push_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = front_valid_r;
  assign push_entry = front_entry_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (front_valid_r && !push_full) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_entry_r.in_win        <= ({1'b0, in_data.frame_seq} < SLOTS4);
      front_entry_r.frame_seq     <= in_data.frame_seq;
      front_entry_r.frame_payload <= in_data.frame_payload;
    end
  end

endmodule
`default_nettype wire

### sv/rrw_queue.sv
// Short FIFO that decouples the front stage from the delivery engine.
`default_nettype none
module rrw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_full,
  input  wire rrw_pkg::q_entry_t  push_entry,
  output logic                    pop_valid,
  input  wire logic               pop,
  output rrw_pkg::q_entry_t       pop_entry
);

  rrw_pkg::q_entry_t              q_mem [rrw_pkg::Q_DEPTH];
  logic [rrw_pkg::Q_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rrw_pkg::Q_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rrw_pkg::Q_CW-1:0]       count_r, count_nxt;
  logic                           do_push, do_pop;

  assign push_full = (count_r == rrw_pkg::Q_CW'(rrw_pkg::Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = q_mem[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

### sv/rrw_back.sv
// Delivery engine: window state, reorder store and result output register.
`default_nettype none
module rrw_back #(
  parameter int WINDOW_SIZE = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire rrw_pkg::q_entry_t q_head,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrw_pkg::out_beat_t     out_data
);

  localparam int SLOTS = (WINDOW_SIZE < 8) ? WINDOW_SIZE : 8;
  localparam int SIW   = $clog2(SLOTS);
  localparam logic [3:0] SLOTS4 = 4'(SLOTS);
  localparam logic [8:0] WIN9   = 9'(WINDOW_SIZE);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                     state_r, state_nxt;
  logic [rrw_pkg::EXP_W-1:0]  exp_r, exp_nxt, exp_eff;
  logic [SLOTS-1:0]           present_r, present_nxt;
  logic [31:0]                slot_payload_r [SLOTS];
  logic                       out_valid_r, out_valid_nxt;
  rrw_pkg::out_beat_t         out_data_r, out_data_nxt;
  logic                       can_emit;
  logic                       wr_en;
  logic [SIW-1:0]             seq_idx, exp_idx;
  logic [3:0]                 seq_ext;

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign seq_idx   = q_head.frame_seq[SIW-1:0];
  assign exp_idx   = exp_r[SIW-1:0];
  assign seq_ext   = {1'b0, q_head.frame_seq};

  // Frame 0 with the counter at the window end restarts the window.
  always_comb begin
    exp_eff = exp_r;
    if (q_head.frame_seq == 3'd0 && {5'b0, exp_r} == WIN9) begin
      exp_eff = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && can_emit) begin
          q_pop = 1'b1;
          // Out-of-window and old frames vanish here.
          if (q_head.in_win && !(seq_ext < exp_eff)) begin
            state_nxt = ST_DRAIN;
            if (seq_ext == exp_eff) begin
              out_valid_nxt        = 1'b1;
              out_data_nxt         = '0;
              out_data_nxt.out_kind    = rrw_pkg::KIND_DELIVER;
              out_data_nxt.out_payload = q_head.frame_payload;
              present_nxt[seq_idx] = 1'b0;
              exp_nxt              = exp_eff + 1'b1;
            end else begin
              exp_nxt = exp_eff;
              if (!present_r[seq_idx]) begin
                present_nxt[seq_idx] = 1'b1;
                wr_en                = 1'b1;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (exp_r < SLOTS4 && present_r[exp_idx]) begin
            out_data_nxt.out_kind    = rrw_pkg::KIND_DELIVER;
            out_data_nxt.out_payload = slot_payload_r[exp_idx];
            present_nxt[exp_idx]     = 1'b0;
            exp_nxt                  = exp_r + 1'b1;
          end else begin
            out_data_nxt.out_kind    = rrw_pkg::KIND_ACK;
            out_data_nxt.ack_number  = exp_r;
            out_data_nxt.last_of_run = 1'b1;
            state_nxt                = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_payload_r[seq_idx] <= q_head.frame_payload;
    end
  end

endmodule
`default_nettype wire

### sv/reorder_receive_window_unit.sv
// Top level of the reorder receive window: front stage, dispatch queue, delivery engine.
`default_nettype none
// Receive side of a selective-repeat link. Each input beat is one checked frame
// (3-bit sequence number, 32-bit payload descriptor). An in-order frame is
// delivered at once, followed by every buffered frame that has become in order,
// and the run closes with an ack beat (out_kind = 1, last_of_run = 1) that
// carries the new expected sequence. A newer frame is parked in its slot unless
// the slot is occupied; it still yields an ack. Old frames and frames beyond the
// window produce no beats. The delivery engine takes one frame at a time from the
// queue in its idle state, where an in-order frame puts out its own delivery. An
// in-window frame that is not old then sends the engine to its drain state,
// which puts out the buffered frames that have become in order and then the
// ack, all through the engine's single output register; no new frame is taken
// until the ack is out. A two-entry queue and a front register let up to three
// further frames be taken while the engine works. Store depth is min(WINDOW_SIZE, 8).
module reorder_receive_window_unit #(
  parameter int WINDOW_SIZE = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrw_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrw_pkg::out_beat_t     out_data
);

  logic              push_valid, push_full;
  rrw_pkg::q_entry_t push_entry;
  logic              q_valid, q_pop;
  rrw_pkg::q_entry_t q_head;

  // Accept and classify.
  rrw_front #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_full (push_full),
    .push_entry(push_entry)
  );

  // Decoupling queue.
  rrw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_full (push_full),
    .push_entry(push_entry),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_entry (q_head)
  );

  // Window state, store, and result beats.
  rrw_back #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

### tb/reorder_receive_window_unit_test.sv
// Testbench for the reorder receive window: directed table, random frame rounds, scoreboard.
`timescale 1ns / 100ps

module reorder_receive_window_unit_test;

  localparam int CLK_PERIOD = 10;
  localparam int WIN        = 8;    // window size the block is built with
  localparam int MAX_OUT    = 10;   // result cap per frame
  localparam int RAND_ITEMS = 500;  // frames that do something, random part
  localparam int TAIL_ITEMS = 60;   // last stretch runs with no idling
  localparam int LONG_HOLD  = 80;   // long receiver hold-off, in cycles
  localparam int QUIET_MAX  = 2000; // watchdog: cycles with no beat moving
  localparam int END_PAD    = 16;   // settle time after the last result
  localparam int DIR_N      = 20;

  // How a directed row is checked: from the predictor, or from a typed value.
  typedef enum logic [1:0] {
    CHK_MODEL,    // predictor supplies the results
    CHK_NONE,     // frame is dropped, nothing comes out
    CHK_ACK,      // frame is parked (or discarded), ack only
    CHK_DLV_ACK   // frame delivered on its own, then ack
  } row_chk_t;

  typedef struct packed {
    logic [2:0]  seq;
    logic [31:0] payload;
    row_chk_t    chk;
    logic [3:0]  ack;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  rrw_pkg::in_beat_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  rrw_pkg::out_beat_t out_data;

  always #(CLK_PERIOD / 2) clk = ~clk;

  reorder_receive_window_unit #(
    .WINDOW_SIZE(WIN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of the expected counter and reorder store.
  // ---------------------------------------------------------------------------
  logic [3:0]         next_seq;
  logic               held         [0:WIN-1];
  logic [31:0]        held_payload [0:WIN-1];
  rrw_pkg::out_beat_t step_out     [0:MAX_OUT-1];  // results of the latest frame

  rrw_pkg::out_beat_t pending_beats [$];           // results still to come, in order

  int frames_in    = 0;
  int handled      = 0;   // frames that produced results
  int dropped      = 0;
  int beats_seen   = 0;
  int err_cnt      = 0;
  int longest_run  = 0;
  int quiet        = 0;

  // Receiver process state; idle_on and hold_token are set by the stimulus side.
  logic idle_on    = 1'b1;
  int   hold_token = 0;
  int   hold_seen  = 0;
  int   rx_left    = 0;

  rrw_pkg::out_beat_t want_beat;

  function automatic rrw_pkg::out_beat_t make_beat(input logic kind,
                                                   input logic [31:0] pay,
                                                   input logic [3:0] ack_no,
                                                   input logic last);
    rrw_pkg::out_beat_t b;
    b.out_kind    = kind;
    b.out_payload = pay;
    b.ack_number  = ack_no;
    b.last_of_run = last;
    return b;
  endfunction

  // Apply one frame to the predicted window; fills step_out, returns the count.
  function automatic int step_window(input rrw_pkg::in_beat_t f);
    int         n;
    logic [3:0] s;
    n = 0;
    s = {1'b0, f.frame_seq};
    if (s >= WIN) return 0;                       // beyond a narrow window
    if (s == 0 && next_seq == WIN) next_seq = '0; // wrap back to frame 0
    if (s < next_seq) return 0;                   // old frame, dropped
    if (s == next_seq) begin
      step_out[n] = make_beat(rrw_pkg::KIND_DELIVER, f.frame_payload, 4'd0, 1'b0);
      n++;
      held[s[2:0]] = 1'b0;
      next_seq++;
    end else if (!held[s[2:0]]) begin
      held[s[2:0]]         = 1'b1;
      held_payload[s[2:0]] = f.frame_payload;
    end
    // Drain whatever has become in order, never past the window edge.
    while (next_seq < WIN && held[next_seq[2:0]] && n < MAX_OUT - 1) begin
      step_out[n] = make_beat(rrw_pkg::KIND_DELIVER, held_payload[next_seq[2:0]],
                              4'd0, 1'b0);
      n++;
      held[next_seq[2:0]] = 1'b0;
      next_seq++;
    end
    step_out[n] = make_beat(rrw_pkg::KIND_ACK, 32'd0, next_seq, 1'b1);
    n++;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one frame, hold it until taken, then book its results. Typed rows
  // push their written expectation; the predictor still steps to stay in sync.
  task automatic send_frame(input rrw_pkg::in_beat_t f, input row_chk_t chk,
                            input logic [3:0] ack_no);
    int n;
    int i;
    int gap;
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_in++;
    n = step_window(f);
    if (n != 0) handled++;
    else dropped++;
    if (n > longest_run) longest_run = n;
    case (chk)
      CHK_MODEL: begin
        for (i = 0; i < n; i++) pending_beats.push_back(step_out[i]);
      end
      CHK_ACK: begin
        pending_beats.push_back(make_beat(rrw_pkg::KIND_ACK, 32'd0, ack_no, 1'b1));
      end
      CHK_DLV_ACK: begin
        pending_beats.push_back(make_beat(rrw_pkg::KIND_DELIVER, f.frame_payload,
                                          4'd0, 1'b0));
        pending_beats.push_back(make_beat(rrw_pkg::KIND_ACK, 32'd0, ack_no, 1'b1));
      end
      default: ;
    endcase
    gap = 0;
    if (idle_on && $urandom_range(5, 0) == 0) gap = $urandom_range(6, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random frame, any sequence number; just noise for the window.
  task automatic send_noise;
    rrw_pkg::in_beat_t f;
    f.frame_seq     = 3'($urandom_range(7, 0));
    f.frame_payload = $urandom();
    send_frame(f, CHK_MODEL, 4'd0);
  endtask

  task automatic send_seq(input int seq);
    rrw_pkg::in_beat_t f;
    f.frame_seq     = 3'(seq);
    f.frame_payload = $urandom();
    send_frame(f, CHK_MODEL, 4'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_left   <= 0;
    end else if (rx_left != 0) begin
      rx_left   <= rx_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_token) begin
      // long hold: the block backs up and must stall its input
      hold_seen <= hold_token;
      rx_left   <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(7, 0) == 0) begin
      rx_left   <= $urandom_range(5, 0);  // random stall burst
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each beat taken against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        want_beat = pending_beats.pop_front();
        beats_seen++;
        if (out_data.out_kind !== want_beat.out_kind) begin
          $display("%0t: out_kind expected %0d actual %0d", $time,
                   want_beat.out_kind, out_data.out_kind);
          err_cnt++;
        end
        if (out_data.out_payload !== want_beat.out_payload) begin
          $display("%0t: out_payload expected %h actual %h", $time,
                   want_beat.out_payload, out_data.out_payload);
          err_cnt++;
        end
        if (out_data.ack_number !== want_beat.ack_number) begin
          $display("%0t: ack_number expected %0d actual %0d", $time,
                   want_beat.ack_number, out_data.ack_number);
          err_cnt++;
        end
        if (out_data.last_of_run !== want_beat.last_of_run) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time,
                   want_beat.last_of_run, out_data.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, quiet, pending_beats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [0:DIR_N-1];

  // Always idles the input before it checks, so the next offer lands in a later step.
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  initial begin
    int                k;
    int                j;
    int                t;
    int                m;
    int                s0;
    int                lo;
    int                tmp;
    int                round;
    int                dir_handled;
    logic              broken;
    logic              tail;
    int                order [0:WIN-1];
    rrw_pkg::in_beat_t f;

    next_seq = '0;
    for (k = 0; k < WIN; k++) begin
      held[k]         = 1'b0;
      held_payload[k] = '0;
    end

    // Directed rows. From reset: park 7..1 (with one taken slot), then frame 0
    // drains the whole window in one run. Then old frames at the window edge,
    // the wrap on frame 0, an old frame after the wrap, and short drains.
    dir_tab = '{
      '{3'd7, 32'hA5A5_A5A5, CHK_ACK,     4'd0},
      '{3'd6, 32'h5A5A_5A5A, CHK_ACK,     4'd0},
      '{3'd6, 32'hDEAD_BEEF, CHK_ACK,     4'd0},  // slot taken, discarded
      '{3'd5, 32'h0000_0001, CHK_ACK,     4'd0},
      '{3'd4, 32'h8000_0000, CHK_ACK,     4'd0},
      '{3'd3, 32'hFFFF_FFFF, CHK_ACK,     4'd0},
      '{3'd2, 32'h0F0F_0F0F, CHK_ACK,     4'd0},
      '{3'd1, 32'hF0F0_F0F0, CHK_ACK,     4'd0},
      '{3'd0, 32'h0000_0000, CHK_MODEL,   4'd0},  // longest run: 8 beats + ack
      '{3'd3, 32'h1357_2468, CHK_NONE,    4'd0},  // old, window full
      '{3'd7, 32'hFFFF_FFFF, CHK_NONE,    4'd0},
      '{3'd0, 32'hFFFF_FFFF, CHK_DLV_ACK, 4'd1},  // wrap
      '{3'd1, 32'h0000_0000, CHK_DLV_ACK, 4'd2},
      '{3'd0, 32'hCAFE_F00D, CHK_NONE,    4'd0},  // old after wrap
      '{3'd5, 32'h1111_1111, CHK_ACK,     4'd2},
      '{3'd3, 32'h2222_2222, CHK_ACK,     4'd2},
      '{3'd2, 32'h3333_3333, CHK_MODEL,   4'd0},
      '{3'd4, 32'h4444_4444, CHK_MODEL,   4'd0},
      '{3'd7, 32'h7777_7777, CHK_ACK,     4'd6},
      '{3'd6, 32'h6666_6666, CHK_MODEL,   4'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_N; k++) begin
      f.frame_seq     = dir_tab[k].seq;
      f.frame_payload = dir_tab[k].payload;
      send_frame(f, dir_tab[k].chk, dir_tab[k].ack);
    end
    dir_handled = handled;

    // Random rounds. Most rounds are a well-formed window: frame 0 first after
    // a full window, then the rest shuffled, with duplicates and noise mixed
    // in. Now and then a broken round sends all eight in any order.
    round = 0;
    while (handled - dir_handled < RAND_ITEMS) begin
      tail = (handled - dir_handled >= RAND_ITEMS - TAIL_ITEMS);
      idle_on <= !tail && (round % 6 != 5);
      if (round == 5 || round == 33) hold_token <= hold_token + 1;
      if (round == 12 || round == 40) wait_drained();

      broken = ($urandom_range(9, 0) == 0);
      m  = 0;
      s0 = 0;
      if (!broken && next_seq == WIN) begin
        order[0] = 0;
        m  = 1;
        s0 = 1;
        lo = 1;
      end else begin
        lo = broken ? 0 : int'(next_seq);
      end
      for (k = lo; k < WIN; k++) begin
        order[m] = k;
        m++;
      end
      for (k = m - 1; k > s0; k--) begin
        j        = $urandom_range(k, s0);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end

      for (k = 0; k < m; k++) begin
        t = $urandom_range(19, 0);
        if (t < 2) send_noise();
        else if (t < 4 && k > 0) send_seq(order[$urandom_range(k - 1, 0)]);  // resend
        send_seq(order[k]);
      end
      round++;
    end

    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (END_PAD) @(posedge clk);

    $display("Ran %0d frames (%0d directed, %0d rounds): %0d acted on, %0d dropped.",
             frames_in, DIR_N, round, handled, dropped);
    $display("Checked %0d result beats; longest run per frame %0d beats.",
             beats_seen, longest_run);
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
